FILE: src/ptm_pkg.sv
// Page table map engine: shared types and constants.
// Beat structs, controller/datapath command and status structs, state and code names.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptm_pkg;

    // Table geometry (fixed)
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int LEVELS            = 4;
    localparam int IDX_W             = 9;

    // Request kinds
    localparam logic [1:0] KIND_MAP   = 2'd0;
    localparam logic [1:0] KIND_REMAP = 2'd1;
    localparam logic [1:0] KIND_UNMAP = 2'd2;

    // Result codes
    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOMEM   = 2'd2
    } t_status;

    // Request beat
    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] virt_addr;
        logic [51:0] phys_addr;
        logic [2:0]  prot;
    } t_req;

    // Result beat
    typedef struct packed {
        t_status     status;
        logic [63:0] entry_value;
    } t_rsp;

    // Controller states
    typedef enum logic [2:0] {
        S_ROOT_CLR,
        S_IDLE,
        S_WALK_RD,
        S_WALK_CHK,
        S_FRAME_CLR,
        S_LINK,
        S_LEAF_WR,
        S_FINISH
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic    load;
        logic    rd;
        logic    descend;
        logic    alloc;
        logic    clr;
        logic    link;
        logic    leaf_wr;
        logic    res_load;
        t_status res_status;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic present;
        logic frames_left;
        logic clr_last;
        logic level_zero;
        logic is_map;
        logic kind_ok;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: src/page_table_map_engine.sv
// Page table map engine, top level. One request at a time; a walk visits each level
// with a read state, then a check state. Each new table frame adds a 512-entry clear
// and a link write. A new request is taken while a result waits.
// Reset: the root frame's 512 entries are cleared; no request is taken then.
// Depends on ptm_pkg, ptm_ctrl, ptm_dpath.
`timescale 1ns / 1ps
`default_nettype none

module page_table_map_engine
    import ptm_pkg::*;
#(
    parameter int TABLE_FRAMES = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    input  wire t_req i_req,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_ready,
    output t_rsp      o_rsp
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer
    ptm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Table store and walk datapath
    ptm_dpath #(
        .TABLE_FRAMES (TABLE_FRAMES)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

FILE: src/ptm_ctrl.sv
// Page table map engine: controller state machine.
// Sequences root clear, table walk, frame allocation/clear and leaf update.
// Depends on ptm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptm_ctrl
    import ptm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_req_valid,
    output logic          o_req_ready,
    output logic          o_rsp_valid,
    input  wire logic     i_rsp_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state  r_state, n_state;
    t_status r_st, n_st;
    logic    r_out_valid, n_out_valid;

    // State and pending result code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ROOT_CLR;
            r_st        <= ST_DONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_st        <= n_st;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state          = r_state;
        n_st             = r_st;
        n_out_valid      = r_out_valid && !i_rsp_ready;
        o_req_ready      = 1'b0;
        o_cmd            = '0;
        o_cmd.res_status = r_st;
        case (r_state)
            S_ROOT_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                if (!i_stat.kind_ok) begin
                    n_st    = ST_INVALID;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_WALK_CHK;
                end
            end
            S_WALK_CHK: begin
                if (i_stat.level_zero) begin
                    // leaf: map needs it empty, remap/unmap need it present
                    if (i_stat.is_map == i_stat.present) begin
                        n_st    = ST_INVALID;
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_LEAF_WR;
                    end
                end else if (i_stat.present) begin
                    o_cmd.descend = 1'b1;
                    n_state       = S_WALK_RD;
                end else if (!i_stat.is_map) begin
                    n_st    = ST_INVALID;
                    n_state = S_FINISH;
                end else if (!i_stat.frames_left) begin
                    n_st    = ST_NOMEM;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.alloc = 1'b1;
                    n_state     = S_FRAME_CLR;
                end
            end
            S_FRAME_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) n_state = S_LINK;
            end
            S_LINK: begin
                o_cmd.link = 1'b1;
                n_state    = S_WALK_RD;
            end
            S_LEAF_WR: begin
                o_cmd.leaf_wr = 1'b1;
                n_st          = ST_DONE;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                // wait for the output register to drain
                if (!r_out_valid || i_rsp_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rsp_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: src/ptm_dpath.sv
// Page table map engine: datapath.
// Table store memory, walk registers, frame bump counter and result register.
// Depends on ptm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptm_dpath
    import ptm_pkg::*;
#(
    parameter int TABLE_FRAMES = 64
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_req    i_req,
    input  wire t_dp_cmd i_cmd,
    output t_dp_stat     o_stat,
    output t_rsp         o_rsp
);

    localparam int FW    = $clog2(TABLE_FRAMES);
    localparam int AW    = FW + IDX_W;
    localparam int DEPTH = TABLE_FRAMES * ENTRIES_PER_TABLE;

    logic [63:0]    r_mem [DEPTH];
    t_req           r_req;
    logic [1:0]     r_level;
    logic [FW-1:0]  r_frame;
    logic [FW:0]    r_next_free;
    logic [IDX_W-1:0] r_clr_idx;
    logic [AW-1:0]  r_link_addr;
    logic [63:0]    r_rd_data;
    t_rsp           r_rsp;

    logic [IDX_W-1:0] w_idx;
    logic [AW-1:0]    w_addr;
    logic [63:0]      w_map_val;
    logic [63:0]      w_remap_val;
    logic [63:0]      w_leaf_val;
    logic [63:0]      w_link_val;
    logic             w_wr_en;
    logic [AW-1:0]    w_wr_addr;
    logic [63:0]      w_wr_data;

    // Table index for the current level
    always_comb begin
        case (r_level)
            2'd3:    w_idx = r_req.virt_addr[47:39];
            2'd2:    w_idx = r_req.virt_addr[38:30];
            2'd1:    w_idx = r_req.virt_addr[29:21];
            default: w_idx = r_req.virt_addr[20:12];
        endcase
    end

    assign w_addr = {r_frame, w_idx};

    // Entry values: NX set unless execute, then addr, user, write, present
    assign w_map_val   = {~r_req.prot[1], 11'b0, r_req.phys_addr[51:12], 9'b0,
                          r_req.prot[2], r_req.prot[0], 1'b1};
    assign w_remap_val = {~r_req.prot[1], 11'b0, r_rd_data[51:12], 9'b0,
                          r_req.prot[2], r_req.prot[0], 1'b1};
    assign w_leaf_val  = (r_req.kind == KIND_MAP)   ? w_map_val :
                         (r_req.kind == KIND_REMAP) ? w_remap_val : 64'd0;
    assign w_link_val  = 64'({r_frame, 9'b0, 3'b111});

    // Write port select
    assign w_wr_en   = i_cmd.clr || i_cmd.link || i_cmd.leaf_wr;
    assign w_wr_addr = i_cmd.clr  ? {r_frame, r_clr_idx} :
                       i_cmd.link ? r_link_addr : w_addr;
    assign w_wr_data = i_cmd.clr  ? 64'd0 :
                       i_cmd.link ? w_link_val : w_leaf_val;

    // Table store
    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_wr_addr] <= w_wr_data;
        if (i_cmd.rd) r_rd_data <= r_mem[w_addr];
    end

    // Walk control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame     <= '0;
            r_clr_idx   <= '0;
            r_next_free <= (FW+1)'(1);
        end else begin
            if (i_cmd.load) begin
                r_frame <= '0;
            end else if (i_cmd.alloc) begin
                r_frame     <= r_next_free[FW-1:0];
                r_next_free <= r_next_free + 1'b1;
            end else if (i_cmd.descend) begin
                r_frame <= r_rd_data[12 +: FW];
            end
            if (i_cmd.alloc) r_clr_idx <= '0;
            else if (i_cmd.clr) r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    // Request, level and parent slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_req;
            r_level <= 2'd3;
        end else if (i_cmd.descend || i_cmd.link) begin
            r_level <= r_level - 1'b1;
        end
        if (i_cmd.alloc) r_link_addr <= w_addr;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_rsp.status      <= i_cmd.res_status;
            r_rsp.entry_value <= (i_cmd.res_status == ST_DONE) ? w_leaf_val : 64'd0;
        end
    end

    // Status to controller
    assign o_stat.present     = r_rd_data[0];
    assign o_stat.frames_left = r_next_free < (FW+1)'(TABLE_FRAMES);
    assign o_stat.clr_last    = (r_clr_idx == '1);
    assign o_stat.level_zero  = (r_level == 2'd0);
    assign o_stat.is_map      = (r_req.kind == KIND_MAP);
    assign o_stat.kind_ok     = (r_req.kind == KIND_MAP) || (r_req.kind == KIND_REMAP)
                                || (r_req.kind == KIND_UNMAP);

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

FILE: src/ptm_checker.sv
// Page table map engine: port-level checker and its bind to the top level.
// Depends on ptm_pkg and page_table_map_engine.
`timescale 1ns / 1ps
`default_nettype none

module ptm_checker
    import ptm_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_req_valid,
    input wire logic o_req_ready,
    input wire t_req i_req,
    input wire logic o_rsp_valid,
    input wire logic i_rsp_ready,
    input wire t_rsp o_rsp
);

    // Reset drops the result beat
    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("result valid after reset");

    // Stalled result beat holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("result beat changed while stalled");

    // Only one request in work at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request taken while another is in work");

    // Failed requests report no entry; written entries are present
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.status != ST_DONE) |-> (o_rsp.entry_value == 64'd0))
        else $error("nonzero entry on failed request");

    a_entry_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.entry_value != 64'd0) |-> o_rsp.entry_value[0])
        else $error("written entry lacks present bit");

endmodule

bind page_table_map_engine ptm_checker u_ptm_checker (.*);

`default_nettype wire
